FILE: design/sbsh_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package sbsh_pkg;

    localparam int WORD_W = 32;
    localparam int BLOCK_W = 512;
    localparam int LEN_W = 64;
    localparam logic [5:0] LEN_SLOT = 6'd56;
    localparam logic [5:0] LAST_SLOT = 6'd63;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        BYTE_DATA,
        BYTE_PAD,
        BYTE_ZERO
    } byte_sel_t;

    typedef struct packed {
        logic      push;
        byte_sel_t byte_sel;
        logic      count_bits;
        logic      load_len;
        logic      load_vars;
        logic      round_step;
        logic      hash_add;
        logic      emit_adv;
        logic      restart;
    } cmd_t;

    typedef struct packed {
        logic [5:0] pending;
        logic       round_last;
        logic       word_last;
    } stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
        rotr = (x >> r) | (x << (32 - r));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        case (i)
            3'd0:    init_hash = 32'h6a09e667;
            3'd1:    init_hash = 32'hbb67ae85;
            3'd2:    init_hash = 32'h3c6ef372;
            3'd3:    init_hash = 32'ha54ff53a;
            3'd4:    init_hash = 32'h510e527f;
            3'd5:    init_hash = 32'h9b05688c;
            3'd6:    init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        case (i)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

FILE: design/sbsh_dpath.sv
// Datapath: block window, message schedule, round unit, hash state and counters.
module sbsh_dpath (
    input  logic                aclk,
    input  logic                aresetn,
    input  sbsh_pkg::cmd_t      cmd,
    input  logic [7:0]          data_byte,
    output sbsh_pkg::stat_t     st,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index
);

    logic [sbsh_pkg::BLOCK_W-1:0] win_reg;
    logic [sbsh_pkg::BLOCK_W-1:0] win_next;
    logic [5:0]                   pend_reg;
    logic [sbsh_pkg::LEN_W-1:0]   bits_reg;
    logic [31:0]                  hash_reg [8];
    logic [31:0]                  v_reg [8];
    logic [5:0]                   rnd_reg;
    logic [2:0]                   idx_reg;

    logic [7:0]  push_byte;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] t1, t2;

    always_comb begin
        case (cmd.byte_sel)
            sbsh_pkg::BYTE_DATA: push_byte = data_byte;
            sbsh_pkg::BYTE_PAD:  push_byte = sbsh_pkg::PAD_BYTE;
            default:             push_byte = 8'h00;
        endcase
    end

    assign w0  = win_reg[511:480];
    assign w1  = win_reg[479:448];
    assign w9  = win_reg[223:192];
    assign w14 = win_reg[63:32];
    assign w_new = w0 + sbsh_pkg::small_sigma0(w1) + w9 + sbsh_pkg::small_sigma1(w14);

    assign t1 = v_reg[7] + sbsh_pkg::big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + sbsh_pkg::round_k(rnd_reg) + w0;
    assign t2 = sbsh_pkg::big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb begin
        win_next = win_reg;
        if (cmd.push) begin
            win_next = {win_reg[503:0], push_byte};
        end else if (cmd.load_len) begin
            win_next = {win_reg[447:0], bits_reg};
        end else if (cmd.round_step) begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        if (cmd.load_vars) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= hash_reg[i];
            end
        end else if (cmd.round_step) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            bits_reg <= '0;
            rnd_reg  <= '0;
            idx_reg  <= '0;
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= sbsh_pkg::init_hash(3'(i));
            end
        end else begin
            if (cmd.restart) begin
                pend_reg <= '0;
                bits_reg <= '0;
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= sbsh_pkg::init_hash(3'(i));
                end
            end else begin
                if (cmd.push) begin
                    pend_reg <= pend_reg + 6'd1;
                end else if (cmd.load_len) begin
                    pend_reg <= '0;
                end
                if (cmd.count_bits) begin
                    bits_reg <= bits_reg + 64'd8;
                end
                if (cmd.hash_add) begin
                    for (int i = 0; i < 8; i++) begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                end
            end
            if (cmd.load_vars) begin
                rnd_reg <= '0;
            end else if (cmd.round_step) begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (cmd.emit_adv) begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    assign st.pending    = pend_reg;
    assign st.round_last = (rnd_reg == 6'd63);
    assign st.word_last  = (idx_reg == 3'd7);
    assign digest_word   = hash_reg[idx_reg];
    assign word_index    = idx_reg;

    a_len_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_len |-> pend_reg == sbsh_pkg::LEN_SLOT)
        else $error("length loaded away from its slot");

    a_round_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.round_step && rnd_reg == 6'd63 |=> pend_reg == 6'd0)
        else $error("compressed block left bytes pending");

endmodule

FILE: design/sbsh_ctrl.sv
// Controller: sequences byte intake, padding, compression rounds and digest output.
module sbsh_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_func,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  sbsh_pkg::stat_t  st,
    output sbsh_pkg::cmd_t   cmd
);

    sbsh_pkg::state_t state_reg, state_next;
    logic fin_reg, fin_next;
    logic len_reg, len_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbsh_pkg::ST_IDLE;
            fin_reg   <= 1'b0;
            len_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            len_reg   <= len_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        len_next   = len_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        cmd.byte_sel = sbsh_pkg::BYTE_ZERO;
        case (state_reg)
            sbsh_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.push = 1'b1;
                    if (in_func == sbsh_pkg::FUNC_APPEND) begin
                        cmd.byte_sel   = sbsh_pkg::BYTE_DATA;
                        cmd.count_bits = 1'b1;
                    end else begin
                        cmd.byte_sel = sbsh_pkg::BYTE_PAD;
                        fin_next     = 1'b1;
                    end
                    if (st.pending == sbsh_pkg::LAST_SLOT) begin
                        cmd.load_vars = 1'b1;
                        state_next    = sbsh_pkg::ST_COMP;
                    end else if (in_func == sbsh_pkg::FUNC_FINISH) begin
                        state_next = sbsh_pkg::ST_PAD;
                    end
                end
            end
            sbsh_pkg::ST_PAD: begin
                if (st.pending == sbsh_pkg::LEN_SLOT) begin
                    cmd.load_len  = 1'b1;
                    cmd.load_vars = 1'b1;
                    len_next      = 1'b1;
                    state_next    = sbsh_pkg::ST_COMP;
                end else begin
                    cmd.push = 1'b1;
                    if (st.pending == sbsh_pkg::LAST_SLOT) begin
                        cmd.load_vars = 1'b1;
                        state_next    = sbsh_pkg::ST_COMP;
                    end
                end
            end
            sbsh_pkg::ST_COMP: begin
                cmd.round_step = 1'b1;
                if (st.round_last) begin
                    state_next = sbsh_pkg::ST_ADD;
                end
            end
            sbsh_pkg::ST_ADD: begin
                cmd.hash_add = 1'b1;
                if (len_reg) begin
                    state_next = sbsh_pkg::ST_EMIT;
                end else if (fin_reg) begin
                    state_next = sbsh_pkg::ST_PAD;
                end else begin
                    state_next = sbsh_pkg::ST_IDLE;
                end
            end
            sbsh_pkg::ST_EMIT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    cmd.emit_adv = 1'b1;
                    if (st.word_last) begin
                        cmd.restart = 1'b1;
                        fin_next    = 1'b0;
                        len_next    = 1'b0;
                        state_next  = sbsh_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sbsh_pkg::ST_IDLE;
            end
        endcase
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid))
        else $error("intake and output active together");

    a_comp_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sbsh_pkg::ST_COMP |=>
            state_reg == sbsh_pkg::ST_COMP || state_reg == sbsh_pkg::ST_ADD)
        else $error("compression left early");

    a_last_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_ready && st.word_last |=>
            state_reg == sbsh_pkg::ST_IDLE && !fin_reg && !len_reg)
        else $error("not idle after last digest beat");

    a_len_then_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sbsh_pkg::ST_EMIT |-> fin_reg && len_reg)
        else $error("digest output before length block");

endmodule

FILE: design/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: controller plus datapath.
// Append beat: every 64th byte starts a compression (64 rounds, one hash add).
// Finish beat: 0x80 is pushed, then zero pad bytes up to byte 56, then the length, and
// the block is compressed (twice when 56 or more bytes pend),
// then eight output beats, one per cycle while m_tready is high.
// Synchronous active-low reset loads the initial hash and clears byte and bit counts.
module sha256_byte_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        m_tlast
);

    sbsh_pkg::cmd_t  cmd;
    sbsh_pkg::stat_t st;
    logic [31:0]     digest_word;
    logic [2:0]      word_index;

    sbsh_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_func   (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .st        (st),
        .cmd       (cmd)
    );

    sbsh_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .st          (st),
        .digest_word (digest_word),
        .word_index  (word_index)
    );

    assign m_tdata = {5'd0, word_index, digest_word};
    assign m_tlast = st.word_last;

endmodule

FILE: test/sha256_byte_stream_hasher_tb.sv
// Self-checking testbench for the SHA-256 byte stream hasher: random handshakes, own digest model.
module sha256_byte_stream_hasher_tb;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 300;
    localparam int HOLD_CYCLES = 160;
    localparam int RX_STEADY = 0;
    localparam int RX_HALF = 1;
    localparam int RX_SPARSE = 2;

    typedef struct {
        logic       func;
        logic [7:0] data;
    } hash_item_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tuser = 1'b0;    // [0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [31:0] digest_word, [34:32] word_index, [39:35] zero
    logic        m_tlast;

    sha256_byte_stream_hasher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    logic [31:0] k_tab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0] iv_tab [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0]  hash_st [8];
    logic [7:0]   blk_bytes [64];
    int           fill;
    logic [63:0]  msg_bits;

    hash_item_t   pend_q [$];
    digest_beat_t digest_q [$];
    hash_item_t   next_item;

    int gap_left = 0;
    int burst_left = 1;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int rx_mode = RX_STEADY;
    int rx_left = 0;
    int stall_cycles = 0;
    int mismatches = 0;
    int msgs_hashed = 0;
    int bytes_hashed = 0;
    int beats_checked = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int r);
        logic [63:0] xx;
        xx = {x, x} >> r;
        return xx[31:0];
    endfunction

    function automatic void start_model();
        for (int i = 0; i < 8; i++) hash_st[i] = iv_tab[i];
        fill = 0;
        msg_bits = 64'd0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = hash_st[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) v[j] = v[j-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
    endfunction

    function automatic void absorb_beat(input logic func, input logic [7:0] data);
        digest_beat_t d;
        if (func == sbsh_pkg::FUNC_APPEND) begin
            blk_bytes[fill] = data;
            msg_bits = msg_bits + 64'd8;
            fill++;
            bytes_hashed++;
            if (fill == 64) begin
                sha_compress();
                fill = 0;
            end
        end else begin
            blk_bytes[fill] = 8'h80;
            if (fill >= 56) begin
                for (int i = fill + 1; i < 64; i++) blk_bytes[i] = 8'h00;
                sha_compress();
                for (int i = 0; i < 56; i++) blk_bytes[i] = 8'h00;
            end else begin
                for (int i = fill + 1; i < 56; i++) blk_bytes[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) blk_bytes[56+i] = msg_bits[63-8*i -: 8];
            sha_compress();
            for (int i = 0; i < 8; i++) begin
                d.word = hash_st[i];
                d.idx = i[2:0];
                d.last = (i == 7);
                digest_q.push_back(d);
            end
            msgs_hashed++;
            start_model();
        end
    endfunction

    task automatic push_item(input logic func, input logic [7:0] data);
        hash_item_t it;
        it.func = func;
        it.data = data;
        pend_q.push_back(it);
    endtask

    task automatic queue_message(input int len);
        for (int i = 0; i < len; i++)
            push_item(sbsh_pkg::FUNC_APPEND, 8'($urandom_range(0, 255)));
        push_item(sbsh_pkg::FUNC_FINISH, 8'($urandom_range(0, 255)));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) absorb_beat(s_tuser, s_tdata);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    next_item = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_item.func;
                    s_tdata <= next_item.data;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && m_tvalid) begin
            // hold off the output long enough for the input to back up
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(RX_STEADY, RX_SPARSE);
                rx_left <= $urandom_range(10, 60);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_STEADY: m_tready <= 1'b1;
                RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
                default:   m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        digest_beat_t d;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest beat %h", $time, m_tdata);
                mismatches++;
            end else begin
                d = digest_q.pop_front();
                beats_checked++;
                if (m_tdata[31:0] !== d.word) begin
                    $display("%0t: digest word %0d expected %h got %h",
                             $time, d.idx, d.word, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[34:32] !== d.idx) begin
                    $display("%0t: word index expected %0d got %0d",
                             $time, d.idx, m_tdata[34:32]);
                    mismatches++;
                end
                if (m_tlast !== d.last) begin
                    $display("%0t: last flag on word %0d expected %b got %b",
                             $time, d.idx, d.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        int len;
        int rand_items;
        int rand_msgs;
        bit timed_out;
        timed_out = 1'b0;
        start_model();
        for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;

        push_item(sbsh_pkg::FUNC_FINISH, 8'h00);
        push_item(sbsh_pkg::FUNC_FINISH, 8'hff);
        push_item(sbsh_pkg::FUNC_APPEND, 8'h00);
        push_item(sbsh_pkg::FUNC_APPEND, 8'hff);
        push_item(sbsh_pkg::FUNC_FINISH, 8'h5a);
        push_item(sbsh_pkg::FUNC_APPEND, 8'h61);
        push_item(sbsh_pkg::FUNC_APPEND, 8'h62);
        push_item(sbsh_pkg::FUNC_APPEND, 8'h63);
        push_item(sbsh_pkg::FUNC_FINISH, 8'h00);
        push_item(sbsh_pkg::FUNC_APPEND, 8'haa);
        push_item(sbsh_pkg::FUNC_APPEND, 8'h55);
        push_item(sbsh_pkg::FUNC_APPEND, 8'h01);
        push_item(sbsh_pkg::FUNC_APPEND, 8'h80);
        push_item(sbsh_pkg::FUNC_APPEND, 8'h7f);
        push_item(sbsh_pkg::FUNC_FINISH, 8'hff);

        // one long message crosses a full block and finishes with 56+ bytes pending
        len = $urandom_range(120, 123);
        queue_message(len);
        rand_items = len + 1;
        rand_msgs = 1;
        while (rand_items < 110 || rand_msgs < 2) begin
            len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            queue_message(len);
            rand_items += len + 1;
            rand_msgs++;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pend_q.size() > 0 || s_tvalid || digest_q.size() > 0) begin
            @(posedge aclk);
            if (stall_cycles >= STALL_LIMIT) begin
                timed_out = 1'b1;
                break;
            end
        end
        if (!timed_out) repeat (TAIL_CYCLES) @(posedge aclk);
        if (timed_out) $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        if (!timed_out && digest_q.size() > 0) begin
            $display("%0t: %0d digest beats never arrived", $time, digest_q.size());
            mismatches++;
        end

        $display("hashed %0d messages over %0d bytes, checked %0d digest beats",
                 msgs_hashed, bytes_hashed, beats_checked);
        $display("output held off for %0d cycles once, %0d mismatches", HOLD_CYCLES, mismatches);
        if (!timed_out && mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
